// File: rtl/core/npcs_pkg.sv
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared constants and types for the nearest palette color search core.
// ----------------------------------------------------------------------------
`default_nettype none

package npcs_pkg;

   localparam int PALETTE_ENTRIES = 255;
   localparam int COMP_W          = 8;
   localparam int FIELD_W         = 8;
   localparam int INDEX_W         = 8;
   localparam int ERR_W           = 9;
   localparam int DIST_W          = COMP_W + 2;
   localparam int CMP_W           = (DIST_W > ERR_W) ? DIST_W : ERR_W;

   localparam logic [ERR_W-1:0] ERR_START = ERR_W'(256);

   // request opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef logic [COMP_W-1:0] comp_type;

   typedef struct packed {
      comp_type red;
      comp_type green;
      comp_type blue;
   } color_type;

   // palette write broadcast to every cell
   typedef struct packed {
      logic             en;
      logic [INDEX_W-1:0] index;
      color_type        color;
   } wr_type;

   // query word travelling down the chain with its running best
   typedef struct packed {
      logic               valid;
      color_type          color;
      logic [INDEX_W-1:0] best_idx;
      logic [ERR_W-1:0]   best_err;
   } token_type;

endpackage

`default_nettype wire

// File: rtl/core/npcs_if.sv
// ----------------------------------------------------------------------------
// npcs_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface npcs_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] entry_index;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, output op, output entry_index, output red,
                   output green, output blue, input ready);
   modport sink   (input valid, input op, input entry_index, input red,
                   input green, input blue, output ready);
endinterface

interface npcs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] match_index;
   logic [8:0] match_error;

   modport source (output valid, output match_index, output match_error,
                   input ready);
   modport sink   (input valid, input match_index, input match_error,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/core/npcs_cell.sv
// ----------------------------------------------------------------------------
// npcs_cell
// One palette entry plus one chain stage: scores the passing query word
// against the stored color and keeps the better of the two candidates.
// ----------------------------------------------------------------------------
`default_nettype none

module npcs_cell
   import npcs_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [INDEX_W-1:0] cell_index,
   input  wire wr_type             wr,
   input  wire token_type          tok_in,
   output      token_type          tok_out
);

   color_type entry_ff, entry_in;
   token_type tok_ff, tok_in_nxt;

   logic [COMP_W-1:0] diff_r, diff_g, diff_b;
   logic [DIST_W-1:0] distance;

   always_comb begin
      entry_in = entry_ff;
      if (wr.en && (wr.index == cell_index)) begin
         entry_in = wr.color;
      end
   end

   always_comb begin
      diff_r = (entry_ff.red > tok_in.color.red) ?
               entry_ff.red - tok_in.color.red : tok_in.color.red - entry_ff.red;
      diff_g = (entry_ff.green > tok_in.color.green) ?
               entry_ff.green - tok_in.color.green : tok_in.color.green - entry_ff.green;
      diff_b = (entry_ff.blue > tok_in.color.blue) ?
               entry_ff.blue - tok_in.color.blue : tok_in.color.blue - entry_ff.blue;
      distance = DIST_W'(diff_r) + DIST_W'(diff_g) + DIST_W'(diff_b);
   end

   // strict compare: an earlier entry keeps a tie
   always_comb begin
      tok_in_nxt = tok_in;
      if (CMP_W'(distance) < CMP_W'(tok_in.best_err)) begin
         tok_in_nxt.best_idx = cell_index;
         tok_in_nxt.best_err = ERR_W'(CMP_W'(distance));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff     <= '0;
         tok_ff.valid <= 1'b0;
      end else begin
         entry_ff     <= entry_in;
         tok_ff.valid <= tok_in_nxt.valid;
      end
      tok_ff.color    <= tok_in_nxt.color;
      tok_ff.best_idx <= tok_in_nxt.best_idx;
      tok_ff.best_err <= tok_in_nxt.best_err;
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

// File: rtl/core/nearest_palette_color_search_core.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_search_core
// Nearest palette color search by Manhattan distance over a row of cells.
// ----------------------------------------------------------------------------
// Path: a query word passes through the launch register, which loads at
//   acceptance, then one cell per palette entry, then the result register;
//   the cell chain sets its length.
// Queries: a new query is taken only after the last one has left the chain;
//   a stalled result holds off the next query. Writes wait while a query is busy.
// Reset (synchronous): palette cleared to zeros, chain and result emptied.
`default_nettype none

module nearest_palette_color_search_core
   import npcs_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   npcs_req_if.sink   req_if,
   npcs_rsp_if.source rsp_if
);

   // Each cell holds one palette entry. A query word enters cell 0 and steps
   // one cell per cycle carrying the best index and error so far; the word
   // leaving the last cell carries the answer.

   token_type tok [PALETTE_ENTRIES+1];
   token_type launch_ff, launch_in;
   wr_type    wr;

   logic busy_ff, busy_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] match_index_ff;
   logic [ERR_W-1:0]   match_error_ff;
   logic req_fire, query_fire;
   token_type tok_last;

   // Writes wait while a query is in the chain so it sees a fixed palette.
   // A query also waits for the result register to be empty.
   assign req_if.ready = !busy_ff && ((req_if.op == OP_WRITE) || !rsp_valid_ff);
   assign req_fire     = req_if.valid && req_if.ready;
   assign query_fire   = req_fire && (req_if.op == OP_QUERY);

   always_comb begin
      wr.en          = req_fire && (req_if.op == OP_WRITE);
      wr.index       = req_if.entry_index;
      wr.color.red   = req_if.red[COMP_W-1:0];
      wr.color.green = req_if.green[COMP_W-1:0];
      wr.color.blue  = req_if.blue[COMP_W-1:0];
   end

   always_comb begin
      launch_in.valid       = query_fire;
      launch_in.color.red   = req_if.red[COMP_W-1:0];
      launch_in.color.green = req_if.green[COMP_W-1:0];
      launch_in.color.blue  = req_if.blue[COMP_W-1:0];
      launch_in.best_idx    = '0;
      launch_in.best_err    = ERR_START;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         launch_ff.valid <= 1'b0;
      end else begin
         launch_ff.valid <= launch_in.valid;
      end
      launch_ff.color    <= launch_in.color;
      launch_ff.best_idx <= launch_in.best_idx;
      launch_ff.best_err <= launch_in.best_err;
   end

   assign tok[0] = launch_ff;

   for (genvar g = 0; g < PALETTE_ENTRIES; g++) begin : g_cell
      npcs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (INDEX_W'(g)),
         .wr         (wr),
         .tok_in     (tok[g]),
         .tok_out    (tok[g+1])
      );
   end

   assign tok_last = tok[PALETTE_ENTRIES];

   // busy from query acceptance until the word drops into the result register
   always_comb begin
      busy_in = busy_ff;
      if (query_fire) begin
         busy_in = 1'b1;
      end else if (tok_last.valid) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (tok_last.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (tok_last.valid) begin
         match_index_ff <= tok_last.best_idx;
         match_error_ff <= tok_last.best_err;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.match_index = match_index_ff;
   assign rsp_if.match_error = match_error_ff;

endmodule

`default_nettype wire
